### rtl/tvs_pkg.sv
package tvs_pkg;

  // Field widths fixed by the stream format
  localparam int AXIS_W     = 16;
  localparam int NUM_AXES   = 8;
  localparam int BUTTON_W   = 16;
  localparam int AXES_BITS  = NUM_AXES * AXIS_W;
  localparam int IN_DATA_W  = AXES_BITS + BUTTON_W;
  localparam int CMD_LANES  = 3;
  localparam int OUT_DATA_W = CMD_LANES * AXIS_W;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEL_FWD   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEL_SIDE  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEL_TURN  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_FWD  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_SIDE = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_TURN = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_BUTTON    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT   = 3'd7;

  // Register reset values
  localparam logic [2:0]  SEL_FWD_RST   = 3'd1;
  localparam logic [2:0]  SEL_SIDE_RST  = 3'd0;
  localparam logic [2:0]  SEL_TURN_RST  = 3'd2;
  localparam logic [15:0] GAIN_RST      = 16'sd256;
  localparam logic [3:0]  BUTTON_RST    = 4'd5;
  localparam logic [15:0] TIMEOUT_RST   = 16'd250;

  // Item kinds carried in the input tuser
  localparam logic KIND_JOY  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Tick counter saturates here; also its reset (stale) value
  localparam logic [15:0] TICKS_STALE = 16'hFFFF;

  // Control from the top level to each smoothing lane
  typedef struct packed {
    logic adv;   // whole pipeline moves this cycle
    logic push;  // joystick item sits in the history stage
  } lane_ctl_t;

endpackage

### rtl/tvs_ram.sv
module tvs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tvs_lane.sv
module tvs_lane #(
  parameter int HISTORY_LEN = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tvs_pkg::lane_ctl_t                 ctl,
  input  logic signed [tvs_pkg::AXIS_W-1:0]  axis,
  input  logic signed [tvs_pkg::AXIS_W-1:0]  gain,
  input  logic signed [tvs_pkg::AXIS_W-1:0]  old_val,
  output logic signed [tvs_pkg::AXIS_W-1:0]  new_val,
  output logic signed [tvs_pkg::AXIS_W-1:0]  avg
);

  localparam int AW    = tvs_pkg::AXIS_W;
  localparam int L_W   = $clog2(HISTORY_LEN);
  localparam int SUM_W = AW + L_W;
  // Reciprocal of the history length: exact floor for |sum| < 2^SUM_W
  localparam int SH    = SUM_W + L_W;
  localparam int M_W   = SUM_W + 2;
  localparam int QP_W  = SUM_W + M_W;
  localparam logic [M_W-1:0] RECIP =
    M_W'(((64'd1 << SH) + 64'(HISTORY_LEN) - 64'd1) / 64'(HISTORY_LEN));

  logic signed [2*AW-1:0]  prod;
  logic signed [AW:0]      q_shift;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0]        mag;
  logic                    neg2;
  logic [QP_W-1:0]         qprod;
  logic                    neg3;
  logic [AW-1:0]           quot;

  // Stage 1: Q1.15 x Q8.8 product
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      prod <= axis * gain;
    end
  end

  // Floor shift by 15, saturate to 16 bits
  assign q_shift = prod[2*AW-1:AW-1];

  always_comb begin
    if (q_shift[AW] != q_shift[AW-1]) begin
      new_val = q_shift[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      new_val = q_shift[AW-1:0];
    end
  end

  // Running sum: drop the oldest entry, add the new one
  assign sum_next = sum - SUM_W'(old_val) + SUM_W'(new_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.adv && ctl.push) begin
      sum <= sum_next;
    end
  end

  // Stage 2: magnitude and sign of the new sum
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      neg2 <= sum_next[SUM_W-1];
      mag  <= sum_next[SUM_W-1] ? (SUM_W'(0) - sum_next) : sum_next;
    end
  end

  // Stage 3: multiply by the reciprocal
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      neg3  <= neg2;
      qprod <= QP_W'(mag) * QP_W'(RECIP);
    end
  end

  // Truncation toward zero: divide the magnitude, then restore sign
  assign quot = qprod[SH +: AW];
  assign avg  = neg3 ? (AW'(0) - quot) : quot;

endmodule

### rtl/teleop_velocity_smoother_top.sv
// Channel  | Dir | Group          | Carries
// ---------+-----+----------------+-----------------------------------------------
// s_*      | in  | tvalid/tready  | tdata: axis_0..axis_7, button_bits; tuser: kind
// m_*      | out | tvalid/tready  | tdata: cmd_fwd, cmd_side, cmd_turn; tuser: stop
// cfg_*    | in  | write enable   | cfg_addr register index, cfg_wdata value
//
// Four-stage pipeline: accept (product, history read), history update (RAM
// write, running sum), reciprocal multiply, commit (held command, watchdog).
// One item per cycle sustained unless commit stalls; a tick's command is registered
// at commit. The history RAM is read and written at most once per cycle, distinct rows.
// Reset clears all control state at once; per-row valid bits make the
// history read as zero until first written, so no clearing pass is needed.
// The pipeline stalls only when a tick that emits reaches commit while the
// output register is still full and not taken; other items keep flowing.
module teleop_velocity_smoother_top #(
  parameter int HISTORY_LEN = 20
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [tvs_pkg::IN_DATA_W-1:0]         s_tdata,  // axis_0..axis_7, button_bits
  input  logic                                  s_tuser,  // kind
  // Output stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [tvs_pkg::OUT_DATA_W-1:0]        m_tdata,  // cmd_fwd, cmd_side, cmd_turn
  output logic                                  m_tuser,  // stop_issued
  // Configuration
  input  logic                                  cfg_we,
  input  logic [tvs_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [15:0]                           cfg_wdata
);

  localparam int AW  = tvs_pkg::AXIS_W;
  localparam int L_W = $clog2(HISTORY_LEN);
  localparam int NL  = tvs_pkg::CMD_LANES;

  // Configuration registers
  logic [2:0]           sel_fwd, sel_side, sel_turn;
  logic signed [AW-1:0] gain_fwd, gain_side, gain_turn;
  logic [3:0]           button_sel;
  logic [15:0]          timeout_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_fwd       <= tvs_pkg::SEL_FWD_RST;
      sel_side      <= tvs_pkg::SEL_SIDE_RST;
      sel_turn      <= tvs_pkg::SEL_TURN_RST;
      gain_fwd      <= tvs_pkg::GAIN_RST;
      gain_side     <= tvs_pkg::GAIN_RST;
      gain_turn     <= tvs_pkg::GAIN_RST;
      button_sel    <= tvs_pkg::BUTTON_RST;
      timeout_ticks <= tvs_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tvs_pkg::CFG_SEL_FWD:   sel_fwd       <= cfg_wdata[2:0];
        tvs_pkg::CFG_SEL_SIDE:  sel_side      <= cfg_wdata[2:0];
        tvs_pkg::CFG_SEL_TURN:  sel_turn      <= cfg_wdata[2:0];
        tvs_pkg::CFG_GAIN_FWD:  gain_fwd      <= cfg_wdata;
        tvs_pkg::CFG_GAIN_SIDE: gain_side     <= cfg_wdata;
        tvs_pkg::CFG_GAIN_TURN: gain_turn     <= cfg_wdata;
        tvs_pkg::CFG_BUTTON:    button_sel    <= cfg_wdata[3:0];
        tvs_pkg::CFG_TIMEOUT:   timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic                 adv;
  logic                 accept;
  logic                 v1, v2, v3;
  logic                 kind1, kind2, kind3;
  logic                 btn1, btn2, btn3;
  logic [L_W-1:0]       ptr;
  logic [L_W-1:0]       waddr1;
  logic                 joy1;
  tvs_pkg::lane_ctl_t   lane_ctl;

  // Watchdog and held command state
  logic [15:0]          ticks;
  logic                 joy_active;
  logic                 enable_held;
  logic signed [AW-1:0] held [NL];
  logic                 fresh;
  logic                 emit_hold;
  logic                 emit_stop;
  logic                 emit3;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = adv;
  assign joy1     = v1 && (kind1 == tvs_pkg::KIND_JOY);
  assign lane_ctl = '{adv: adv, push: joy1};

  // Axis picking; selectors beyond the wired axes read as zero
  function automatic logic signed [AW-1:0] pick_axis(
    input logic [tvs_pkg::IN_DATA_W-1:0] d,
    input logic [2:0]                    sel
  );
    logic signed [AW-1:0] r;
    r = '0;
    if (32'(sel) < tvs_pkg::NUM_AXES) begin
      r = d[{sel, 4'b0000} +: AW];
    end
    return r;
  endfunction

  logic [tvs_pkg::BUTTON_W-1:0] buttons;
  assign buttons = s_tdata[tvs_pkg::AXES_BITS +: tvs_pkg::BUTTON_W];

  // History pointer advances on each joystick transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (accept && (s_tuser == tvs_pkg::KIND_JOY)) begin
      ptr <= (ptr == L_W'(HISTORY_LEN - 1)) ? '0 : ptr + L_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1  <= s_tuser;
      btn1   <= buttons[button_sel];
      waddr1 <= ptr;
      kind2  <= kind1;
      btn2   <= btn1;
      kind3  <= kind2;
      btn3   <= btn2;
    end
  end

  // History memory: one row holds all three lanes
  logic [HISTORY_LEN-1:0]         hv;
  logic                           hv_q;
  logic [tvs_pkg::OUT_DATA_W-1:0] ram_rdata;
  logic [tvs_pkg::OUT_DATA_W-1:0] ram_wdata;
  logic                           ram_we;

  assign ram_we = adv && joy1;

  tvs_ram #(
    .WIDTH (tvs_pkg::OUT_DATA_W),
    .DEPTH (HISTORY_LEN)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr1),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  // Rows never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      hv   <= '0;
      hv_q <= 1'b0;
    end else begin
      if (adv) begin
        hv_q <= hv[ptr];
      end
      if (ram_we) begin
        hv[waddr1] <= 1'b1;
      end
    end
  end

  logic signed [AW-1:0] lane_axis [NL];
  logic signed [AW-1:0] lane_gain [NL];
  logic signed [AW-1:0] lane_old  [NL];
  logic signed [AW-1:0] lane_new  [NL];
  logic signed [AW-1:0] lane_avg  [NL];

  assign lane_axis[0] = pick_axis(s_tdata, sel_fwd);
  assign lane_axis[1] = pick_axis(s_tdata, sel_side);
  assign lane_axis[2] = pick_axis(s_tdata, sel_turn);
  assign lane_gain[0] = gain_fwd;
  assign lane_gain[1] = gain_side;
  assign lane_gain[2] = gain_turn;

  for (genvar i = 0; i < NL; i++) begin : g_lane
    assign lane_old[i]           = hv_q ? ram_rdata[i*AW +: AW] : '0;
    assign ram_wdata[i*AW +: AW] = lane_new[i];

    tvs_lane #(
      .HISTORY_LEN (HISTORY_LEN)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (lane_ctl),
      .axis    (lane_axis[i]),
      .gain    (lane_gain[i]),
      .old_val (lane_old[i]),
      .new_val (lane_new[i]),
      .avg     (lane_avg[i])
    );
  end

  // Commit stage: watchdog decision for ticks
  assign fresh     = ticks < timeout_ticks;
  assign emit_hold = fresh || enable_held;
  assign emit_stop = !emit_hold && joy_active;
  assign emit3     = v3 && (kind3 == tvs_pkg::KIND_TICK) && (emit_hold || emit_stop);
  assign adv       = !(emit3 && m_tvalid && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks       <= tvs_pkg::TICKS_STALE;
      joy_active  <= 1'b0;
      enable_held <= 1'b0;
      for (int i = 0; i < NL; i++) begin
        held[i] <= '0;
      end
    end else if (adv && v3) begin
      if (kind3 == tvs_pkg::KIND_JOY) begin
        ticks       <= '0;
        joy_active  <= 1'b1;
        enable_held <= btn3;
        for (int i = 0; i < NL; i++) begin
          held[i] <= lane_avg[i];
        end
      end else begin
        if (ticks != tvs_pkg::TICKS_STALE) begin
          ticks <= ticks + 16'd1;
        end
        if (emit_stop) begin
          joy_active <= 1'b0;
          for (int i = 0; i < NL; i++) begin
            held[i] <= '0;
          end
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && emit3) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit3) begin
      m_tuser <= emit_stop;
      for (int i = 0; i < NL; i++) begin
        m_tdata[i*AW +: AW] <= emit_hold ? held[i] : '0;
      end
    end
  end

  // Checks
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, ptr} < (L_W + 1)'(HISTORY_LEN))
    else $error("history pointer out of range");

  a_no_row_clash: assert property (@(posedge clk) disable iff (rst)
    (adv && joy1 && accept) |-> (waddr1 != ptr))
    else $error("history read and write hit the same row");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("stop command carries non-zero velocity");

  a_stop_drops: assert property (@(posedge clk) disable iff (rst)
    (adv && emit3 && emit_stop) |=> (!joy_active && m_tvalid && m_tuser))
    else $error("stop did not clear active flag");

  a_joy_commit: assert property (@(posedge clk) disable iff (rst)
    (adv && v3 && (kind3 == tvs_pkg::KIND_JOY)) |=> (ticks == '0 && joy_active))
    else $error("joystick commit did not refresh watchdog");

endmodule

### tb/teleop_velocity_smoother_top_tb.sv
module teleop_velocity_smoother_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tvs_pkg::*;

  localparam int HIST_DEPTH     = 20;
  localparam int SETTLE_CYCLES  = 8;     // settle time once no command is owed
  localparam int IDLE_LIMIT     = 5000;  // cycles without any transfer before giving up
  localparam int HOLD_CYCLES    = 300;   // long output back-pressure stretch
  localparam int PHASES         = 15;
  localparam int PHASE_ITEMS    = 110;
  localparam int PRESSURE_PHASE = 12;
  localparam int REPORT_MAX     = 10;

  // One input transfer: tuser carries kind, tdata carries buttons over the axes
  typedef struct packed {
    logic             kind;
    logic [15:0]      buttons;
    logic [7:0][15:0] axes;     // axes[0] sits in the lowest tdata bits
  } joy_item_t;

  // One output transfer
  typedef struct packed {
    logic [15:0] fwd;
    logic [15:0] side;
    logic [15:0] turn;
    logic        stop;
  } cmd_t;

  typedef enum logic [1:0] {ROW_JOY, ROW_TICK, ROW_CFG} row_op_e;

  // Directed stimulus row; fixed marks a result typed in by hand
  typedef struct packed {
    row_op_e                 op;
    logic [CFG_ADDR_W-1:0]   cfg_idx;
    logic [15:0]             cfg_val;
    joy_item_t               item;
    logic                    fixed;
    logic                    emits;
    cmd_t                    cmd;
  } dir_row_t;

  localparam cmd_t NO_CMD   = '0;
  localparam cmd_t STOP_CMD = {16'd0, 16'd0, 16'd0, 1'b1};

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata   = '0;   // axis_0..axis_7, button_bits
  logic                    s_tuser   = 1'b0; // kind
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;          // cmd_fwd, cmd_side, cmd_turn
  logic                    m_tuser;          // stop_issued
  logic                    cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr  = '0;
  logic [15:0]             cfg_wdata = '0;

  teleop_velocity_smoother_top #(
    .HISTORY_LEN(HIST_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the register file, updated as each register write goes out
  // ---------------------------------------------------------------------------
  logic [2:0]         axis_sel  [3] = '{SEL_FWD_RST, SEL_SIDE_RST, SEL_TURN_RST};
  logic signed [15:0] lane_gain [3] = '{GAIN_RST, GAIN_RST, GAIN_RST};
  logic [3:0]         button_sel    = BUTTON_RST;
  logic [15:0]        timeout_cfg   = TIMEOUT_RST;

  // ---------------------------------------------------------------------------
  // Smoother state as the predictor sees it; lanes are fwd, side, turn
  // ---------------------------------------------------------------------------
  logic signed [15:0] lane_hist [3][HIST_DEPTH] = '{default: '0};
  int                 lane_sum  [3] = '{0, 0, 0};
  logic signed [15:0] lane_held [3] = '{16'sd0, 16'sd0, 16'sd0};
  int                 hist_wr       = 0;
  logic [15:0]        ticks_idle    = TICKS_STALE;
  logic               joy_live      = 1'b0;
  logic               deadman       = 1'b0;

  cmd_t pending_cmds[$];   // commands still owed by the block, oldest first

  // Idle percentages per side, set per phase by the stimulus
  int   tx_idle_pct  = 0;
  int   rx_idle_pct  = 0;
  logic hold_off_req = 1'b0;
  int   hold_left    = 0;

  int fault_count = 0;
  int joy_count   = 0;
  int tick_count  = 0;
  int cmd_count   = 0;
  int stop_count  = 0;
  int stall_count = 0;
  int cfg_sets    = 0;

  // Q1.15 axis times Q8.8 gain, floor to Q8.8, clamped to 16 bits
  function automatic logic signed [15:0] scale_q(input logic [15:0] axis,
                                                 input logic signed [15:0] gain);
    int p;
    p = int'($signed(axis)) * int'(gain);
    p = p >>> 15;
    if (p > 32767) p = 32767;
    else if (p < -32768) p = -32768;
    return 16'(p);
  endfunction

  // Moves the shadow state on by one accepted item; returns 1 when a command is owed
  function automatic logic advance_smoother(input joy_item_t it, output cmd_t res);
    logic signed [15:0] v;
    logic               fresh;
    res = NO_CMD;
    if (it.kind == KIND_JOY) begin
      for (int lane = 0; lane < 3; lane++) begin
        v = scale_q(it.axes[axis_sel[lane]], lane_gain[lane]);
        lane_sum[lane] = lane_sum[lane] - int'(lane_hist[lane][hist_wr]) + int'(v);
        lane_hist[lane][hist_wr] = v;
        // integer divide truncates toward zero, as the averaging wants
        lane_held[lane] = 16'(lane_sum[lane] / HIST_DEPTH);
      end
      hist_wr    = (hist_wr == HIST_DEPTH - 1) ? 0 : hist_wr + 1;
      joy_live   = 1'b1;
      deadman    = it.buttons[button_sel];
      ticks_idle = '0;
      return 1'b0;
    end
    // send tick: freshness is judged before the counter moves on
    fresh = ticks_idle < timeout_cfg;
    if (ticks_idle != TICKS_STALE) ticks_idle++;
    if (fresh || deadman) begin
      res.fwd  = lane_held[0];
      res.side = lane_held[1];
      res.turn = lane_held[2];
      return 1'b1;
    end
    if (joy_live) begin
      // one zero command on timeout; the history is left as it stands
      for (int lane = 0; lane < 3; lane++) lane_held[lane] = '0;
      joy_live = 1'b0;
      res      = STOP_CMD;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return GAIN_RST;
      3:       return 16'($urandom_range(0, 1024) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic joy_item_t random_item(input logic kind);
    joy_item_t it;
    it.kind    = kind;
    it.buttons = 16'($urandom);
    for (int a = 0; a < 8; a++) it.axes[a] = rand_axis();
    return it;
  endfunction

  function automatic dir_row_t joy_row(input logic [15:0] a0, a1, a2, a7, btn);
    dir_row_t r;
    r = '0;
    r.op           = ROW_JOY;
    r.item.kind    = KIND_JOY;
    r.item.axes[0] = a0;
    r.item.axes[1] = a1;
    r.item.axes[2] = a2;
    r.item.axes[7] = a7;
    r.item.buttons = btn;
    return r;
  endfunction

  function automatic dir_row_t tick_row(input logic fixed, input logic emits, input cmd_t cmd);
    dir_row_t r;
    r = '0;
    r.op        = ROW_TICK;
    r.item.kind = KIND_TICK;
    r.fixed     = fixed;
    r.emits     = emits;
    r.cmd       = cmd;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_ADDR_W-1:0] idx,
                                       input logic [15:0] val);
    dir_row_t r;
    r = '0;
    r.op      = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  // Register write; only ever issued with the block drained
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SEL_FWD:   axis_sel[0]  = val[2:0];
      CFG_SEL_SIDE:  axis_sel[1]  = val[2:0];
      CFG_SEL_TURN:  axis_sel[2]  = val[2:0];
      CFG_GAIN_FWD:  lane_gain[0] = val;
      CFG_GAIN_SIDE: lane_gain[1] = val;
      CFG_GAIN_TURN: lane_gain[2] = val;
      CFG_BUTTON:    button_sel   = val[3:0];
      CFG_TIMEOUT:   timeout_cfg  = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drop tvalid, let every owed command arrive, then let the pipe settle, since
  // joystick items still in flight leave nothing in the queue to wait on
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one item, hold it until the transfer, then book what it owes
  task automatic offer_input(input joy_item_t it, input logic fixed,
                             input logic fixed_emits, input cmd_t fixed_cmd);
    cmd_t want;
    logic emits;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {it.buttons, it.axes};
    s_tuser  <= it.kind;
    do @(posedge clk); while (!s_tready);
    emits = advance_smoother(it, want);
    if (fixed) begin
      emits = fixed_emits;
      want  = fixed_cmd;
    end
    if (emits) pending_cmds.push_back(want);
    if (it.kind == KIND_JOY) joy_count++;
    else tick_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random tready, one long hold-off on request, and the checker.
  // Handshake values are taken as they stood at the edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : cmd_sink
    cmd_t got;
    cmd_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.fwd  = m_tdata[15:0];
        got.side = m_tdata[31:16];
        got.turn = m_tdata[47:32];
        got.stop = m_tuser;
        if (pending_cmds.size() == 0) begin
          if (fault_count < REPORT_MAX)
            $display("%0t: command with none owed: fwd=%0d side=%0d turn=%0d stop=%0b",
                     $time, $signed(got.fwd), $signed(got.side), $signed(got.turn),
                     got.stop);
          fault_count++;
        end else begin
          want = pending_cmds.pop_front();
          cmd_count++;
          if (want.stop) stop_count++;
          if (got.fwd !== want.fwd || got.side !== want.side ||
              got.turn !== want.turn || got.stop !== want.stop) begin
            if (fault_count < REPORT_MAX)
              $display("%0t: mismatch got fwd=%0d side=%0d turn=%0d stop=%0b, want fwd=%0d side=%0d turn=%0d stop=%0b",
                       $time, $signed(got.fwd), $signed(got.side), $signed(got.turn),
                       got.stop, $signed(want.fwd), $signed(want.side),
                       $signed(want.turn), want.stop);
            fault_count++;
          end
        end
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: a stretch with no transfer on either side ends the run
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_count = 0;
    else stall_count++;
    if (stall_count >= IDLE_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d commands still owed",
               IDLE_LIMIT, pending_cmds.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  dir_row_t directed_rows[$];

  initial begin : stimulus
    joy_item_t   it;
    dir_row_t    row;
    logic [15:0] tmo_pick;
    int          sent;
    int          n_joy;
    int          n_tick;
    int          dm_mode;
    int          r;

    // Directed table. Stale tick straight after reset owes nothing.
    directed_rows.push_back(tick_row(1'b1, 1'b0, NO_CMD));
    // full-scale axes on fwd and side, half-scale on turn, unit gains
    directed_rows.push_back(joy_row(16'h8000, 16'h7FFF, 16'h4000, 16'h0000, 16'h0000));
    directed_rows.push_back(tick_row(1'b0, 1'b0, NO_CMD));
    // timeout of one: the second tick after the joystick stops, the next is silent
    directed_rows.push_back(cfg_row(CFG_TIMEOUT, 16'd1));
    directed_rows.push_back(tick_row(1'b1, 1'b1, STOP_CMD));
    directed_rows.push_back(tick_row(1'b1, 1'b0, NO_CMD));
    // extreme gains, saturation on the fwd lane, every button down
    directed_rows.push_back(cfg_row(CFG_GAIN_FWD, 16'h8000));
    directed_rows.push_back(cfg_row(CFG_GAIN_SIDE, 16'h7FFF));
    directed_rows.push_back(joy_row(16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 16'hFFFF));
    // zero timeout: only the deadman keeps the command going
    directed_rows.push_back(cfg_row(CFG_TIMEOUT, 16'd0));
    directed_rows.push_back(tick_row(1'b0, 1'b0, NO_CMD));
    directed_rows.push_back(tick_row(1'b0, 1'b0, NO_CMD));
    // deadman released: first tick is the stop
    directed_rows.push_back(joy_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFDF));
    directed_rows.push_back(tick_row(1'b1, 1'b1, STOP_CMD));
    directed_rows.push_back(tick_row(1'b1, 1'b0, NO_CMD));
    // longest timeout, deadman bit alone
    directed_rows.push_back(cfg_row(CFG_TIMEOUT, 16'hFFFF));
    directed_rows.push_back(joy_row(16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0020));
    directed_rows.push_back(tick_row(1'b0, 1'b0, NO_CMD));
    // top button index and top axis selector
    directed_rows.push_back(cfg_row(CFG_BUTTON, 16'd15));
    directed_rows.push_back(cfg_row(CFG_SEL_TURN, 16'd7));
    directed_rows.push_back(joy_row(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000));
    directed_rows.push_back(tick_row(1'b0, 1'b0, NO_CMD));
    directed_rows.push_back(tick_row(1'b0, 1'b0, NO_CMD));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 19;
    rx_idle_pct = 58;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.op == ROW_CFG) begin
        wait_idle();
        write_reg(row.cfg_idx, row.cfg_val);
      end else begin
        offer_input(row.item, row.fixed, row.emits, row.cmd);
      end
    end

    // Random phases: each one reprograms every register, then runs bursts of
    // joystick items followed by tick runs, some long enough to cross a short timeout
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 5) begin
        tx_idle_pct = 19;
        rx_idle_pct = 58;
      end else if (ph < 10) begin
        tx_idle_pct = 58;
        rx_idle_pct = 19;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      wait_idle();
      cfg_sets++;
      if (ph == 0) begin
        write_reg(CFG_SEL_FWD, 16'd7);
        write_reg(CFG_SEL_SIDE, 16'd7);
        write_reg(CFG_SEL_TURN, 16'd7);
        write_reg(CFG_GAIN_FWD, 16'h7FFF);
        write_reg(CFG_GAIN_SIDE, 16'h7FFF);
        write_reg(CFG_GAIN_TURN, 16'h7FFF);
        write_reg(CFG_BUTTON, 16'd15);
        write_reg(CFG_TIMEOUT, 16'hFFFF);
      end else if (ph == 1) begin
        write_reg(CFG_SEL_FWD, 16'd0);
        write_reg(CFG_SEL_SIDE, 16'd0);
        write_reg(CFG_SEL_TURN, 16'd0);
        write_reg(CFG_GAIN_FWD, 16'h8000);
        write_reg(CFG_GAIN_SIDE, 16'h8000);
        write_reg(CFG_GAIN_TURN, 16'h8000);
        write_reg(CFG_BUTTON, 16'd0);
        write_reg(CFG_TIMEOUT, 16'd1);
      end else begin
        r = $urandom_range(0, 9);
        if (ph == PRESSURE_PHASE) tmo_pick = 16'hFFFF;  // every tick emits
        else if (r == 0) tmo_pick = 16'd0;
        else if (r == 1) tmo_pick = TIMEOUT_RST;
        else tmo_pick = 16'($urandom_range(1, 12));
        write_reg(CFG_SEL_FWD, 16'($urandom_range(0, 7)));
        write_reg(CFG_SEL_SIDE, 16'($urandom_range(0, 7)));
        write_reg(CFG_SEL_TURN, 16'($urandom_range(0, 7)));
        write_reg(CFG_GAIN_FWD, rand_gain());
        write_reg(CFG_GAIN_SIDE, rand_gain());
        write_reg(CFG_GAIN_TURN, rand_gain());
        write_reg(CFG_BUTTON, 16'($urandom_range(0, 15)));
        write_reg(CFG_TIMEOUT, tmo_pick);
      end

      // sink stops taking commands for a long while so the pipe backs up
      if (ph == PRESSURE_PHASE) hold_off_req = 1'b1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray item of either kind
          it = random_item(1'($urandom_range(0, 1)));
          offer_input(it, 1'b0, 1'b0, NO_CMD);
          sent++;
        end else begin
          n_joy   = $urandom_range(1, 24);   // sometimes enough to wrap the history
          n_tick  = (timeout_cfg <= 12) ? $urandom_range(0, timeout_cfg + 4)
                                        : $urandom_range(0, 30);
          dm_mode = $urandom_range(0, 2);    // deadman up, down or left to chance
          repeat (n_joy) begin
            it = random_item(KIND_JOY);
            if (dm_mode == 0) it.buttons[button_sel] = 1'b0;
            else if (dm_mode == 1) it.buttons[button_sel] = 1'b1;
            offer_input(it, 1'b0, 1'b0, NO_CMD);
            sent++;
          end
          repeat (n_tick) begin
            it = random_item(KIND_TICK);
            offer_input(it, 1'b0, 1'b0, NO_CMD);
            sent++;
          end
        end
      end
    end

    wait_idle();
    $display("Run covered %0d joystick and %0d tick transfers over %0d register sets;",
             joy_count, tick_count, cfg_sets + 1);
    $display("%0d commands checked, %0d of them timeout stops, one long sink hold-off.",
             cmd_count, stop_count);
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d faults", fault_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
